@@ src/tol_pkg.sv @@
// shared types and constants of the time-ordered operator list
package tol_pkg;

    localparam int CAPACITY = 64;
    localparam int FLAVORS  = 2;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam cnt_t CAP_CNT   = cnt_t'(CAPACITY);
    localparam cnt_t LAST_STEP = cnt_t'(CAPACITY - 1);
    localparam cnt_t ADD_LIMIT = cnt_t'(CAPACITY - 2);

    // operation codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SHIFT  = 2'd2;

    // error codes
    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_FULL    = 2'd1;
    localparam logic [1:0] ERR_MISSING = 2'd2;

    typedef struct packed {
        logic [1:0]  code;
        logic [31:0] tstamp;
    } entry_t;

    // per-cycle moves of the cell chain
    typedef struct packed {
        logic s_rot;
        logic t_rot;
        logic commit;
    } cell_ctrl_t;

    // decoded operation
    typedef struct packed {
        logic [1:0]  op;
        entry_t      hi;
        entry_t      lo;
        logic [1:0]  sh_code;
        logic [31:0] time_a;
        logic [31:0] time_b;
        logic        commit;
    } cmd_t;

    typedef struct packed {
        logic start;
        logic step;
    } scan_ctrl_t;

    // list edit found by the scan: two insertions, two deletions
    typedef struct packed {
        logic       ins_a_v;
        cnt_t       ins_a_pos;
        entry_t     ins_a;
        logic       ins_b_v;
        cnt_t       ins_b_pos;
        entry_t     ins_b;
        logic       del_a_v;
        idx_t       del_a_pos;
        logic       del_b_v;
        idx_t       del_b_pos;
        logic [1:0] err;
        cnt_t       m;
    } edit_t;

endpackage

@@ src/tol_cell.sv @@
// one cell of the chain: a stored entry and a trial entry
module tol_cell (
    input  logic                clk,
    input  tol_pkg::cell_ctrl_t ctrl,
    input  tol_pkg::entry_t     s_in,
    input  tol_pkg::entry_t     t_in,
    output tol_pkg::entry_t     s_out,
    output tol_pkg::entry_t     t_out
);

    tol_pkg::entry_t s_reg;
    tol_pkg::entry_t s_next;
    tol_pkg::entry_t t_reg;
    tol_pkg::entry_t t_next;

    always_comb
    begin
        s_next = s_reg;
        t_next = t_reg;
        if (ctrl.commit)
        begin
            s_next = t_reg;
        end
        else if (ctrl.s_rot)
        begin
            s_next = s_in;
        end
        if (ctrl.t_rot)
        begin
            t_next = t_in;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        t_reg <= t_next;
    end

    assign s_out = s_reg;
    assign t_out = t_reg;

endmodule

@@ src/tol_scan.sv @@
// search pass trackers and the resulting list edit
module tol_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  tol_pkg::scan_ctrl_t ctrl,
    input  tol_pkg::idx_t       index,
    input  tol_pkg::entry_t     head,
    input  tol_pkg::cmd_t       cmd,
    input  tol_pkg::cnt_t       count,
    output tol_pkg::edit_t      edit
);

    // add: insertion points
    tol_pkg::cnt_t p1_reg, p1_next;
    tol_pkg::cnt_t p2_reg, p2_next;
    tol_pkg::cnt_t le2_reg, le2_next;
    // remove: last matches
    tol_pkg::idx_t last2_reg, last2_next;
    logic          last2_v_reg, last2_v_next;
    tol_pkg::idx_t d1_reg, d1_next;
    tol_pkg::idx_t d2_reg, d2_next;
    logic          found_rm_reg, found_rm_next;
    // shift
    tol_pkg::idx_t k_reg, k_next;
    tol_pkg::idx_t q_reg, q_next;
    tol_pkg::idx_t p_reg, p_next;
    logic          found_k_reg, found_k_next;
    logic          adv_reg, adv_next;
    logic          found_p_reg, found_p_next;

    tol_pkg::cnt_t i1;
    tol_pkg::cnt_t le2_now;
    logic          gt;
    logic          match1;
    logic          match2;
    logic          match_sh;
    logic          fp_now;

    assign i1       = tol_pkg::cnt_t'(index) + tol_pkg::cnt_t'(1);
    assign gt       = cmd.time_b > cmd.time_a;
    assign match1   = (head.tstamp == cmd.hi.tstamp) && (head.code == cmd.hi.code);
    assign match2   = (head.tstamp == cmd.lo.tstamp) && (head.code == cmd.lo.code);
    assign match_sh = (head.tstamp == cmd.time_a) && (head.code == cmd.sh_code);
    assign le2_now  = (head.tstamp <= cmd.lo.tstamp) ? i1 : le2_reg;
    assign fp_now   = found_p_reg || (head.tstamp >= cmd.time_b);

    always_comb
    begin
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        le2_next      = le2_reg;
        last2_next    = last2_reg;
        last2_v_next  = last2_v_reg;
        d1_next       = d1_reg;
        d2_next       = d2_reg;
        found_rm_next = found_rm_reg;
        k_next        = k_reg;
        q_next        = q_reg;
        p_next        = p_reg;
        found_k_next  = found_k_reg;
        adv_next      = adv_reg;
        found_p_next  = found_p_reg;
        if (ctrl.start)
        begin
            p1_next       = '0;
            p2_next       = '0;
            le2_next      = '0;
            last2_next    = '0;
            last2_v_next  = 1'b0;
            d1_next       = '0;
            d2_next       = '0;
            found_rm_next = 1'b0;
            k_next        = '0;
            q_next        = '0;
            p_next        = '0;
            found_k_next  = 1'b0;
            adv_next      = 1'b0;
            found_p_next  = 1'b0;
        end
        else if (ctrl.step)
        begin
            // add: last entry not above each new time
            le2_next = le2_now;
            if (head.tstamp <= cmd.hi.tstamp)
            begin
                p1_next = i1;
                p2_next = le2_now;
            end
            // remove: latest later-time match with an earlier-time match before it
            if (match1)
            begin
                found_rm_next = last2_v_reg;
                d1_next       = index;
                d2_next       = last2_reg;
            end
            if (match2)
            begin
                last2_next   = index;
                last2_v_next = 1'b1;
            end
            // shift
            if (gt)
            begin
                if (!found_k_reg)
                begin
                    if (match_sh)
                    begin
                        found_k_next = 1'b1;
                        k_next       = index;
                        q_next       = index;
                        adv_next     = 1'b1;
                    end
                end
                else if (adv_reg)
                begin
                    if (head.tstamp < cmd.time_b)
                    begin
                        q_next = index;
                    end
                    else
                    begin
                        adv_next = 1'b0;
                    end
                end
            end
            else
            begin
                found_p_next = fp_now;
                if (!found_p_reg && fp_now)
                begin
                    p_next = index;
                end
                if (fp_now && !found_k_reg && match_sh)
                begin
                    found_k_next = 1'b1;
                    k_next       = index;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg       <= '0;
            p2_reg       <= '0;
            le2_reg      <= '0;
            last2_reg    <= '0;
            last2_v_reg  <= 1'b0;
            d1_reg       <= '0;
            d2_reg       <= '0;
            found_rm_reg <= 1'b0;
            k_reg        <= '0;
            q_reg        <= '0;
            p_reg        <= '0;
            found_k_reg  <= 1'b0;
            adv_reg      <= 1'b0;
            found_p_reg  <= 1'b0;
        end
        else
        begin
            p1_reg       <= p1_next;
            p2_reg       <= p2_next;
            le2_reg      <= le2_next;
            last2_reg    <= last2_next;
            last2_v_reg  <= last2_v_next;
            d1_reg       <= d1_next;
            d2_reg       <= d2_next;
            found_rm_reg <= found_rm_next;
            k_reg        <= k_next;
            q_reg        <= q_next;
            p_reg        <= p_next;
            found_k_reg  <= found_k_next;
            adv_reg      <= adv_next;
            found_p_reg  <= found_p_next;
        end
    end

    always_comb
    begin
        edit     = '0;
        edit.err = tol_pkg::ERR_OK;
        edit.m   = count;
        case (cmd.op)
            tol_pkg::OP_ADD:
            begin
                if (count > tol_pkg::ADD_LIMIT)
                begin
                    edit.err = tol_pkg::ERR_FULL;
                end
                else
                begin
                    edit.ins_a_v   = 1'b1;
                    edit.ins_a_pos = p2_reg;
                    edit.ins_a     = cmd.lo;
                    edit.ins_b_v   = 1'b1;
                    edit.ins_b_pos = p1_reg;
                    edit.ins_b     = cmd.hi;
                    edit.m         = count + tol_pkg::cnt_t'(2);
                end
            end
            tol_pkg::OP_REMOVE:
            begin
                if (!found_rm_reg)
                begin
                    edit.err = tol_pkg::ERR_MISSING;
                end
                else
                begin
                    edit.del_a_v   = 1'b1;
                    edit.del_a_pos = d2_reg;
                    edit.del_b_v   = 1'b1;
                    edit.del_b_pos = d1_reg;
                    edit.m         = count - tol_pkg::cnt_t'(2);
                end
            end
            tol_pkg::OP_SHIFT:
            begin
                if (!found_k_reg)
                begin
                    edit.err = tol_pkg::ERR_MISSING;
                end
                else
                begin
                    edit.del_a_v       = 1'b1;
                    edit.del_a_pos     = k_reg;
                    edit.ins_a_v       = 1'b1;
                    edit.ins_a.code    = cmd.sh_code;
                    edit.ins_a.tstamp  = cmd.time_b;
                    edit.ins_a_pos     = gt ? tol_pkg::cnt_t'(q_reg) + tol_pkg::cnt_t'(1)
                                            : tol_pkg::cnt_t'(p_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ src/time_ordered_operator_list.sv @@
// top level: time-sorted operator list held in a ring of cells
//
// The list lives in a chain of CAPACITY cells, each holding one stored entry and
// one trial entry; the stored entries turn as a ring whose head cell is the
// only one looked at. An operation takes one full turn of the ring to search,
// then streams the trial list out one transfer a cycle while the output takes
// it, passing over each deleted entry without a transfer, while the trial chain
// fills from its tail. A final alignment phase finishes the turns of both rings
// and, when commit is set and no error was found, copies the trial list into
// the stored list in all cells at once. An operation spans two full turns of
// the ring, and a new item is taken only once the ring is home.
// Every operation, including an error or an unused operation code, emits the
// whole list; an empty list gives one transfer with list_empty set.
module time_ordered_operator_list (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  operation,
    input  logic        flavor,
    input  logic        which_end,
    input  logic [31:0] time_a,
    input  logic [31:0] time_b,
    input  logic        commit,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  entry_code,
    output logic [31:0] entry_time,
    output logic [5:0]  entry_index,
    output logic        list_empty,
    output logic [1:0]  error,
    output logic        last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT,
        ST_ALIGN
    } state_t;

    state_t              state_reg, state_next;
    tol_pkg::cmd_t       cmd_reg, cmd_next;
    tol_pkg::cnt_t       s_cnt_reg, s_cnt_next;
    tol_pkg::cnt_t       t_cnt_reg, t_cnt_next;
    tol_pkg::cnt_t       emit_cnt_reg, emit_cnt_next;
    tol_pkg::cnt_t       count_reg, count_next;
    logic                a_done_reg, a_done_next;
    logic                b_done_reg, b_done_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_code_reg, out_code_next;
    logic [31:0]         out_time_reg, out_time_next;
    logic [5:0]          out_index_reg, out_index_next;
    logic                out_empty_reg, out_empty_next;
    logic [1:0]          out_err_reg, out_err_next;
    logic                out_last_reg, out_last_next;

    tol_pkg::cell_ctrl_t cell_ctrl;
    tol_pkg::scan_ctrl_t scan_ctrl;
    tol_pkg::edit_t      edit;
    tol_pkg::entry_t     s_out [tol_pkg::CAPACITY];
    tol_pkg::entry_t     t_out [tol_pkg::CAPACITY];
    tol_pkg::entry_t     s_in  [tol_pkg::CAPACITY];
    tol_pkg::entry_t     t_in  [tol_pkg::CAPACITY];
    tol_pkg::entry_t     t_tail;
    tol_pkg::entry_t     head;
    tol_pkg::entry_t     emit_ent;

    logic                fl_eff;
    logic [1:0]          code_s;
    logic [1:0]          code_e;
    logic                can_load;
    logic                emit;
    logic                pend_a;
    logic                pend_b;
    logic                in_list;
    logic                deleted;
    logic                is_last;

    assign head = s_out[0];

    // ring of cells: stored entries wrap from the head to the tail,
    // trial entries enter at the tail
    for (genvar j = 0; j < tol_pkg::CAPACITY; j++)
    begin : g_cell
        if (j == tol_pkg::CAPACITY - 1)
        begin : g_tail
            assign s_in[j] = s_out[0];
            assign t_in[j] = t_tail;
        end
        else
        begin : g_mid
            assign s_in[j] = s_out[j+1];
            assign t_in[j] = t_out[j+1];
        end

        tol_cell u_cell (
            .clk   (clk),
            .ctrl  (cell_ctrl),
            .s_in  (s_in[j]),
            .t_in  (t_in[j]),
            .s_out (s_out[j]),
            .t_out (t_out[j])
        );
    end

    tol_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (scan_ctrl),
        .index (s_cnt_reg[tol_pkg::IDX_W-1:0]),
        .head  (head),
        .cmd   (cmd_reg),
        .count (count_reg),
        .edit  (edit)
    );

    // operator codes of the flavor, flavor wrapped to the flavor count
    assign fl_eff = (tol_pkg::FLAVORS > 1) ? flavor : 1'b0;
    assign code_s = {fl_eff, 1'b0};
    assign code_e = {fl_eff, 1'b1};

    assign can_load = !out_valid_reg || result_ready;

    // emission decisions at the current position of the stored list
    assign pend_a  = edit.ins_a_v && !a_done_reg && (s_cnt_reg == edit.ins_a_pos);
    assign pend_b  = edit.ins_b_v && !b_done_reg && (s_cnt_reg == edit.ins_b_pos);
    assign in_list = s_cnt_reg < count_reg;
    assign deleted = (edit.del_a_v && (s_cnt_reg[tol_pkg::IDX_W-1:0] == edit.del_a_pos))
                  || (edit.del_b_v && (s_cnt_reg[tol_pkg::IDX_W-1:0] == edit.del_b_pos));
    assign is_last = (emit_cnt_reg + tol_pkg::cnt_t'(1)) == edit.m;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        s_cnt_next     = s_cnt_reg;
        t_cnt_next     = t_cnt_reg;
        emit_cnt_next  = emit_cnt_reg;
        count_next     = count_reg;
        a_done_next    = a_done_reg;
        b_done_next    = b_done_reg;
        out_valid_next = out_valid_reg;
        out_code_next  = out_code_reg;
        out_time_next  = out_time_reg;
        out_index_next = out_index_reg;
        out_empty_next = out_empty_reg;
        out_err_next   = out_err_reg;
        out_last_next  = out_last_reg;
        cell_ctrl      = '0;
        scan_ctrl      = '0;
        t_tail         = t_out[0];
        emit           = 1'b0;
        emit_ent       = head;

        // a waiting result leaves on its transfer
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd_next.op      = operation;
                    cmd_next.sh_code = which_end ? code_e : code_s;
                    cmd_next.time_a  = time_a;
                    cmd_next.time_b  = time_b;
                    cmd_next.commit  = commit;
                    // later-time entry of the pair goes in hi, start wins ties
                    if (time_a < time_b)
                    begin
                        cmd_next.hi = '{code: code_e, tstamp: time_b};
                        cmd_next.lo = '{code: code_s, tstamp: time_a};
                    end
                    else
                    begin
                        cmd_next.hi = '{code: code_s, tstamp: time_a};
                        cmd_next.lo = '{code: code_e, tstamp: time_b};
                    end
                    scan_ctrl.start = 1'b1;
                    s_cnt_next      = '0;
                    state_next      = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                // one full turn, head cell seen at each index
                scan_ctrl.step  = in_list;
                cell_ctrl.s_rot = 1'b1;
                s_cnt_next      = s_cnt_reg + tol_pkg::cnt_t'(1);
                if (s_cnt_reg == tol_pkg::LAST_STEP)
                begin
                    s_cnt_next    = '0;
                    t_cnt_next    = '0;
                    emit_cnt_next = '0;
                    a_done_next   = 1'b0;
                    b_done_next   = 1'b0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (can_load)
                begin
                    if (edit.m == '0)
                    begin
                        // empty list marker
                        out_valid_next = 1'b1;
                        out_code_next  = '0;
                        out_time_next  = '0;
                        out_index_next = '0;
                        out_empty_next = 1'b1;
                        out_err_next   = edit.err;
                        out_last_next  = 1'b1;
                        state_next     = ST_ALIGN;
                    end
                    else
                    begin
                        if (pend_a)
                        begin
                            emit        = 1'b1;
                            emit_ent    = edit.ins_a;
                            a_done_next = 1'b1;
                        end
                        else if (pend_b)
                        begin
                            emit        = 1'b1;
                            emit_ent    = edit.ins_b;
                            b_done_next = 1'b1;
                        end
                        else if (in_list)
                        begin
                            // consume the head entry, drop it if deleted
                            cell_ctrl.s_rot = 1'b1;
                            s_cnt_next      = s_cnt_reg + tol_pkg::cnt_t'(1);
                            emit            = !deleted;
                            emit_ent        = head;
                        end

                        if (emit)
                        begin
                            cell_ctrl.t_rot = 1'b1;
                            t_tail          = emit_ent;
                            t_cnt_next      = t_cnt_reg + tol_pkg::cnt_t'(1);
                            emit_cnt_next   = emit_cnt_reg + tol_pkg::cnt_t'(1);
                            out_valid_next  = 1'b1;
                            out_code_next   = emit_ent.code;
                            out_time_next   = emit_ent.tstamp;
                            out_index_next  = 6'(emit_cnt_reg);
                            out_empty_next  = 1'b0;
                            out_err_next    = edit.err;
                            out_last_next   = is_last;
                            if (is_last)
                            begin
                                state_next = ST_ALIGN;
                            end
                        end
                    end
                end
            end
            ST_ALIGN:
            begin
                // finish the turns so both lists start at the head cell again
                if (s_cnt_reg != tol_pkg::CAP_CNT)
                begin
                    cell_ctrl.s_rot = 1'b1;
                    s_cnt_next      = s_cnt_reg + tol_pkg::cnt_t'(1);
                end
                if (t_cnt_reg != tol_pkg::CAP_CNT)
                begin
                    cell_ctrl.t_rot = 1'b1;
                    t_cnt_next      = t_cnt_reg + tol_pkg::cnt_t'(1);
                end
                if ((s_cnt_reg == tol_pkg::CAP_CNT) && (t_cnt_reg == tol_pkg::CAP_CNT))
                begin
                    if (cmd_reg.commit && (edit.err == tol_pkg::ERR_OK))
                    begin
                        cell_ctrl.commit = 1'b1;
                        count_next       = edit.m;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= '0;
            s_cnt_reg     <= '0;
            t_cnt_reg     <= '0;
            emit_cnt_reg  <= '0;
            count_reg     <= '0;
            a_done_reg    <= 1'b0;
            b_done_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_code_reg  <= '0;
            out_time_reg  <= '0;
            out_index_reg <= '0;
            out_empty_reg <= 1'b0;
            out_err_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            s_cnt_reg     <= s_cnt_next;
            t_cnt_reg     <= t_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            count_reg     <= count_next;
            a_done_reg    <= a_done_next;
            b_done_reg    <= b_done_next;
            out_valid_reg <= out_valid_next;
            out_code_reg  <= out_code_next;
            out_time_reg  <= out_time_next;
            out_index_reg <= out_index_next;
            out_empty_reg <= out_empty_next;
            out_err_reg   <= out_err_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;
    assign entry_code   = out_code_reg;
    assign entry_time   = out_time_reg;
    assign entry_index  = out_index_reg;
    assign list_empty   = out_empty_reg;
    assign error        = out_err_reg;
    assign last         = out_last_reg;

endmodule

@@ verif/tb_time_ordered_operator_list.sv @@
// testbench for the time-ordered operator list: directed and random list edits against a predictor
`timescale 1ns / 100ps

module tb_time_ordered_operator_list;

    // operation code that the block leaves unused
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // one operation as offered on the input side
    typedef struct packed {
        logic [1:0]  op;
        logic        flavor;
        logic        which_end;
        logic [31:0] time_a;
        logic [31:0] time_b;
        logic        commit;
    } op_request_t;

    // one streamed list entry as seen on the output side
    typedef struct packed {
        logic [1:0]  code;
        logic [31:0] tstamp;
        logic [5:0]  index;
        logic        empty;
        logic [1:0]  err;
        logic        last;
    } list_result_t;

    // a whole operator list with its length
    typedef struct {
        tol_pkg::entry_t ent [tol_pkg::CAPACITY];
        int              n;
    } list_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    logic        result_valid;
    logic        result_ready;
    logic [1:0]  entry_code;
    logic [31:0] entry_time;
    logic [5:0]  entry_index;
    logic        list_empty;
    logic [1:0]  error;
    logic        last;

    // the request currently on the input ports
    op_request_t offered;

    // stimulus waiting to be driven, expected transfers waiting to arrive
    op_request_t  pending_ops [$];
    list_result_t expected_entries [$];

    // list as the block holds it, and as the stimulus generator expects it to be
    list_t stored_list;
    list_t planned_list;

    // idling percentages of the current phase
    int sender_idle_pct = 0;
    int stall_pct = 0;

    // long output hold-off, counted in its own process
    int hold_left;
    bit hold_done;

    // generator mode: grow the list toward full, or drain it toward empty
    bit growing = 1'b1;

    int mismatches = 0;
    int ops_accepted = 0;
    int results_seen = 0;
    int full_errors = 0;
    int missing_errors = 0;
    int commits_done = 0;

    list_result_t got;
    list_result_t want;

    time_ordered_operator_list u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .operation    (offered.op),
        .flavor       (offered.flavor),
        .which_end    (offered.which_end),
        .time_a       (offered.time_a),
        .time_b       (offered.time_b),
        .commit       (offered.commit),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .entry_code   (entry_code),
        .entry_time   (entry_time),
        .entry_index  (entry_index),
        .list_empty   (list_empty),
        .error        (error),
        .last         (last)
    );

    always #5 clk = ~clk;

    // trial list that one operation produces from the current list, with its error code
    function automatic void edit_list(input list_t cur, input op_request_t rq,
                                      output list_t trial, output logic [1:0] err);
        tol_pkg::entry_t hi;
        tol_pkg::entry_t lo;
        tol_pkg::entry_t old_ent;
        tol_pkg::entry_t new_ent;
        logic [1:0]      cs;
        logic [1:0]      ce;
        int              i;
        int              k;
        int              q;
        int              p;
        trial = cur;
        err = tol_pkg::ERR_OK;
        cs = {rq.flavor, 1'b0};
        ce = {rq.flavor, 1'b1};
        // hi is the later entry of the pair; equal times put the start entry as hi
        if (rq.time_a < rq.time_b)
        begin
            hi = '{code: ce, tstamp: rq.time_b};
            lo = '{code: cs, tstamp: rq.time_a};
        end
        else
        begin
            hi = '{code: cs, tstamp: rq.time_a};
            lo = '{code: ce, tstamp: rq.time_b};
        end
        case (rq.op)
            tol_pkg::OP_ADD:
            begin
                if (cur.n + 2 > tol_pkg::CAPACITY)
                    err = tol_pkg::ERR_FULL;
                else
                begin
                    // each new entry lands after stored entries of equal time
                    i = cur.n - 1;
                    while (i >= 0 && cur.ent[i].tstamp > hi.tstamp)
                    begin
                        trial.ent[i + 2] = cur.ent[i];
                        i--;
                    end
                    trial.ent[i + 2] = hi;
                    while (i >= 0 && cur.ent[i].tstamp > lo.tstamp)
                    begin
                        trial.ent[i + 1] = cur.ent[i];
                        i--;
                    end
                    trial.ent[i + 1] = lo;
                    trial.n = cur.n + 2;
                end
            end
            tol_pkg::OP_REMOVE:
            begin
                // scan from the tail: later entry first, then the earlier one below it
                i = cur.n - 1;
                while (i >= 0 && cur.ent[i] != hi)
                begin
                    if (i >= 2)
                        trial.ent[i - 2] = cur.ent[i];
                    i--;
                end
                if (i < 0)
                    err = tol_pkg::ERR_MISSING;
                else
                begin
                    i--;
                    while (i >= 0 && cur.ent[i] != lo)
                    begin
                        if (i >= 1)
                            trial.ent[i - 1] = cur.ent[i];
                        i--;
                    end
                    if (i < 0)
                        err = tol_pkg::ERR_MISSING;
                    else
                        trial.n = cur.n - 2;
                end
            end
            tol_pkg::OP_SHIFT:
            begin
                old_ent = '{code: rq.which_end ? ce : cs, tstamp: rq.time_a};
                new_ent = '{code: rq.which_end ? ce : cs, tstamp: rq.time_b};
                if (rq.time_b > rq.time_a)
                begin
                    // first match from the head moves past entries below the new time
                    k = 0;
                    while (k < cur.n && cur.ent[k] != old_ent)
                        k++;
                    if (k >= cur.n)
                        err = tol_pkg::ERR_MISSING;
                    else
                    begin
                        q = k;
                        while (q != cur.n - 1 && cur.ent[q + 1].tstamp < rq.time_b)
                            q++;
                        for (i = k + 1; i <= q; i++)
                            trial.ent[i - 1] = cur.ent[i];
                        trial.ent[q] = new_ent;
                    end
                end
                else
                begin
                    // goes in front of the first entry at or above the new time
                    p = 0;
                    while (p < cur.n && cur.ent[p].tstamp < rq.time_b)
                        p++;
                    k = p;
                    while (k < cur.n && cur.ent[k] != old_ent)
                        k++;
                    if (k >= cur.n)
                        err = tol_pkg::ERR_MISSING;
                    else
                    begin
                        trial.ent[p] = new_ent;
                        for (i = p; i < k; i++)
                            trial.ent[i + 1] = cur.ent[i];
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (err != tol_pkg::ERR_OK)
            trial = cur;
    endfunction

    // accepted operation: queue the streamed list it causes and update the stored list
    task automatic predict_stream(input op_request_t rq);
        list_t      trial;
        logic [1:0] err;
        int         k;
        edit_list(stored_list, rq, trial, err);
        if (err == tol_pkg::ERR_FULL)
            full_errors++;
        if (err == tol_pkg::ERR_MISSING)
            missing_errors++;
        if (trial.n == 0)
            expected_entries.push_back('{code: 2'd0, tstamp: 32'd0, index: 6'd0,
                                         empty: 1'b1, err: err, last: 1'b1});
        for (k = 0; k < trial.n; k++)
            expected_entries.push_back('{code: trial.ent[k].code,
                                         tstamp: trial.ent[k].tstamp,
                                         index: 6'(k), empty: 1'b0, err: err,
                                         last: (k == trial.n - 1)});
        if (err == tol_pkg::ERR_OK && rq.commit)
        begin
            stored_list = trial;
            commits_done++;
        end
    endtask

    // queue one request and track what the list will look like after it
    task automatic queue_request(input logic [1:0] op, input logic fl, input logic we,
                                 input logic [31:0] ta, input logic [31:0] tb,
                                 input logic cm);
        op_request_t rq;
        list_t       trial;
        logic [1:0]  err;
        rq = '{op: op, flavor: fl, which_end: we, time_a: ta, time_b: tb, commit: cm};
        edit_list(planned_list, rq, trial, err);
        if (err == tol_pkg::ERR_OK && cm)
            planned_list = trial;
        pending_ops.push_back(rq);
    endtask

    // times: wide random, a narrow band for ties, and both extremes
    function automatic logic [31:0] pick_time();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom;
        else if (r < 8)
            return 32'($urandom_range(0, 15));
        else if (r == 8)
            return 32'd0;
        else
            return 32'hFFFF_FFFF;
    endfunction

    // random operations; removes and shifts are mostly aimed at entries that exist
    task automatic queue_random(input int count);
        int              r;
        int              k;
        int              j;
        int              partners [$];
        logic [1:0]      op;
        logic            fl;
        logic            we;
        logic            cm;
        logic [31:0]     ta;
        logic [31:0]     tb;
        tol_pkg::entry_t pick;
        repeat (count)
        begin
            if (planned_list.n >= tol_pkg::CAPACITY)
                growing = 1'b0;
            else if (planned_list.n <= 2)
                growing = 1'b1;
            r = $urandom_range(0, 99);
            fl = 1'($urandom);
            we = 1'($urandom);
            cm = ($urandom_range(0, 9) != 0);
            ta = pick_time();
            tb = pick_time();
            if (r < 6)
                // noise: any code, times that rarely match
                op = 2'($urandom_range(0, 3));
            else
            begin
                r = $urandom_range(0, 99);
                if (growing)
                    op = (r < 62) ? tol_pkg::OP_ADD
                       : (r < 76) ? tol_pkg::OP_REMOVE : tol_pkg::OP_SHIFT;
                else
                    op = (r < 16) ? tol_pkg::OP_ADD
                       : (r < 70) ? tol_pkg::OP_REMOVE : tol_pkg::OP_SHIFT;
                if (planned_list.n == 0)
                    op = tol_pkg::OP_ADD;
                if (op != tol_pkg::OP_ADD)
                begin
                    k = $urandom_range(0, planned_list.n - 1);
                    pick = planned_list.ent[k];
                    fl = pick.code[1];
                    we = pick.code[0];
                    if (op == tol_pkg::OP_SHIFT)
                    begin
                        ta = pick.tstamp;
                        if ($urandom_range(0, 1))
                            tb = ta + 32'($urandom_range(0, 6)) - 32'd3;
                    end
                    else
                    begin
                        // pair it with an entry of the other end of the same flavor
                        partners.delete();
                        for (j = 0; j < planned_list.n; j++)
                            if (planned_list.ent[j].code == {pick.code[1], ~pick.code[0]})
                                partners.push_back(j);
                        if (partners.size() > 0)
                        begin
                            j = partners[$urandom_range(0, partners.size() - 1)];
                            ta = pick.code[0] ? planned_list.ent[j].tstamp : pick.tstamp;
                            tb = pick.code[0] ? pick.tstamp : planned_list.ent[j].tstamp;
                        end
                    end
                end
            end
            queue_request(op, fl, we, ta, tb, cm);
        end
    endtask

    // driver: offers queued requests, predicts on every accepted transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            offered <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                predict_stream(offered);
                ops_accepted++;
            end
            if (!item_valid || item_ready)
            begin
                if (pending_ops.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    offered <= pending_ops.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // one long hold-off early on, so the block backs up and stalls its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && results_seen >= 400)
        begin
            hold_done <= 1'b1;
            hold_left <= 600;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // monitor: checks each output transfer against the oldest expected entry
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                got = '{code: entry_code, tstamp: entry_time, index: entry_index,
                        empty: list_empty, err: error, last: last};
                if (expected_entries.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected nothing, got code %0d time %h index %0d",
                             $time, got.code, got.tstamp, got.index,
                             " empty %0d err %0d last %0d",
                             got.empty, got.err, got.last);
                end
                else
                begin
                    want = expected_entries.pop_front();
                    if (got.code !== want.code || got.tstamp !== want.tstamp ||
                        got.index !== want.index || got.empty !== want.empty ||
                        got.err !== want.err || got.last !== want.last)
                    begin
                        mismatches++;
                        $display("%0t: expected code %0d time %h index %0d", $time,
                                 want.code, want.tstamp, want.index,
                                 " empty %0d err %0d last %0d,",
                                 want.empty, want.err, want.last,
                                 " got code %0d time %h index %0d",
                                 got.code, got.tstamp, got.index,
                                 " empty %0d err %0d last %0d",
                                 got.empty, got.err, got.last);
                    end
                end
            end
            if (hold_left > 0)
                result_ready <= 1'b0;
            else
                result_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // waits until every queued request has gone in and every expected entry came out
    task automatic wait_drained();
        while (pending_ops.size() != 0 || item_valid || expected_entries.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int k;
        rst_n = 1'b0;
        for (k = 0; k < tol_pkg::CAPACITY; k++)
        begin
            stored_list.ent[k] = '0;
            planned_list.ent[k] = '0;
        end
        stored_list.n = 0;
        planned_list.n = 0;

        // empty list: misses, the unused code and the empty marker
        queue_request(tol_pkg::OP_REMOVE, 1'b0, 1'b0, 32'd1, 32'd2, 1'b1);
        queue_request(tol_pkg::OP_SHIFT, 1'b1, 1'b1, 32'd0, 32'd4, 1'b1);
        queue_request(OP_UNUSED, 1'b0, 1'b0, 32'd0, 32'd0, 1'b1);
        // adds: extreme times, equal times, reversed order, ties with stored entries
        queue_request(tol_pkg::OP_ADD, 1'b0, 1'b0, 32'd0, 32'hFFFF_FFFF, 1'b1);
        queue_request(tol_pkg::OP_ADD, 1'b1, 1'b0, 32'd5, 32'd5, 1'b1);
        queue_request(tol_pkg::OP_ADD, 1'b1, 1'b1, 32'd9, 32'd3, 1'b1);
        queue_request(tol_pkg::OP_ADD, 1'b0, 1'b1, 32'd5, 32'd5, 1'b0);
        queue_request(tol_pkg::OP_ADD, 1'b0, 1'b0, 32'd5, 32'd5, 1'b1);
        // shifts: later, earlier, unchanged time, no commit, absent entry
        queue_request(tol_pkg::OP_SHIFT, 1'b0, 1'b0, 32'd0, 32'd5, 1'b1);
        queue_request(tol_pkg::OP_SHIFT, 1'b1, 1'b1, 32'd3, 32'hFFFF_FFFF, 1'b1);
        queue_request(tol_pkg::OP_SHIFT, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'd0, 1'b1);
        queue_request(tol_pkg::OP_SHIFT, 1'b1, 1'b0, 32'd9, 32'd9, 1'b1);
        queue_request(tol_pkg::OP_SHIFT, 1'b0, 1'b0, 32'd5, 32'd1, 1'b0);
        queue_request(tol_pkg::OP_SHIFT, 1'b1, 1'b0, 32'd1234, 32'd0, 1'b1);
        // removes: absent pair, equal times, no commit, then a real one
        queue_request(tol_pkg::OP_REMOVE, 1'b0, 1'b0, 32'd1, 32'd2, 1'b1);
        queue_request(tol_pkg::OP_REMOVE, 1'b1, 1'b0, 32'd5, 32'd5, 1'b0);
        queue_request(tol_pkg::OP_REMOVE, 1'b1, 1'b1, 32'd5, 32'd5, 1'b1);
        queue_request(OP_UNUSED, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_request(tol_pkg::OP_ADD, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        queue_request(tol_pkg::OP_REMOVE, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // phases: no idling, sender gaps, receiver stalls, both
        queue_random(90);
        wait_drained();
        sender_idle_pct = 50;
        stall_pct = 0;
        queue_random(90);
        wait_drained();
        sender_idle_pct = 0;
        stall_pct = 50;
        queue_random(90);
        wait_drained();
        sender_idle_pct = 19;
        stall_pct = 19;
        queue_random(90);
        wait_drained();

        // the ring has to come home before the block is idle
        repeat (2 * tol_pkg::CAPACITY + 10) @(posedge clk);

        $display("covered %0d operations, %0d list transfers, %0d stored commits",
                 ops_accepted, results_seen, commits_done);
        $display("with %0d list-full and %0d entry-missing rejections, idling on both sides",
                 full_errors, missing_errors);
        if (mismatches == 0)
            $display("time_ordered_operator_list: match");
        else
            $display("time_ordered_operator_list: mismatch");
        $finish;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("timeout with %0d transfers still expected", expected_entries.size());
        $display("time_ordered_operator_list: mismatch");
        $finish;
    end

endmodule
